### rtl/core/chip8_instruction_execute_core_macros.svh
// assertion helpers for the execute core checker
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_MACROS_SVH

`define C8_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define C8_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/c8ex_pkg.sv
`timescale 1ns / 1ps
package c8ex_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam logic [11:0] StartAddrRst = 12'h200;
  localparam logic [11:0] PcStep = 12'd2;
  localparam logic [15:0] InstrRet = 16'h00EE;
  localparam logic [15:0] InstrCls = 16'h00E0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_UNSUP = 2'd3
  } status_t;

  typedef enum logic {
    OP_EXEC = 1'b0,
    OP_TICK = 1'b1
  } op_t;

endpackage

### rtl/core/c8ex_ram.sv
`timescale 1ns / 1ps
module c8ex_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/chip8_instruction_execute_core.sv
`timescale 1ns / 1ps
// chip-8 instruction execute core
// input channel: in_valid/in_stall carry one request, either an instruction
// (in_op = 0) with its random byte and key mask, or a 60 Hz timer tick
// (in_op = 1). output channel: out_valid/out_stall carry one result per
// request: pc, index, register write report, vf, delay timer, sound flag
// and status.
// cfg_we/cfg_wdata write the start value; reset restores it to 0x200 and
// loads the pc from that reset value, so a write never reaches the pc.
// a request accepted into the stage register gives its result valid in the
// output register (the stage register holds it while the register file reads,
// execute writes the output register). throughput: one request per cycle while
// the output is not stalled; the stage register and the output register let a
// new request enter while a finished result waits. general registers sit in a
// register file with three registered read copies; writes landing at the read
// edge are forwarded, so back-to-back dependent instructions run at full rate.
// the return stack is a separate ram, read by the depth count ahead of time.
// reset clears registers, timers, index, stack depth and loads the pc.
// while out_stall is high a valid result holds and the pipeline stops; in_stall
// rises only when both stages are full.
module chip8_instruction_execute_core
  import c8ex_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_instr_word,
  input  logic [7:0]  in_random_byte,
  input  logic [15:0] in_key_down_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_next_pc,
  output logic [15:0] out_index_value,
  output logic        out_reg_written,
  output logic [3:0]  out_reg_number,
  output logic [7:0]  out_reg_value,
  output logic [7:0]  out_flag_value,
  output logic [7:0]  out_delay_value,
  output logic        out_sound_on,
  output logic [1:0]  out_status
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SDW = $clog2(STACK_DEPTH + 1);
  localparam logic [SDW-1:0] SdFull = SDW'(STACK_DEPTH);

  // architectural state held in flops
  logic [11:0]    start_r;
  logic [11:0]    pc_r, pc_nxt;
  logic [15:0]    idx_r, idx_nxt;
  logic [SDW-1:0] sd_r, sd_nxt;
  logic [7:0]     dt_r, dt_nxt, st_r, st_nxt;
  logic [7:0]     vf_r, vf_nxt;

  // stage 1: request held while register file reads
  logic        s1_v_r;
  logic        s1_op_r;
  logic [15:0] s1_w_r;
  logic [7:0]  s1_rnd_r;
  logic [15:0] s1_key_r;
  logic        adv;
  logic        s1_ld;

  // register file write port (from execute)
  logic       rf_we;
  logic [3:0] rf_wa;
  logic [7:0] rf_wd;
  // forwarding of writes during the read cycle
  logic       fw_v_r;
  logic [3:0] fw_a_r;
  logic [7:0] fw_d_r;
  logic       fwf_v_r;
  logic [7:0] fwf_d_r;
  // written marks, so registers never written since reset read as zero
  logic [15:0] rv_r;
  logic        rvx_r, rvy_r, rv0_r;

  logic [7:0] rx_q, ry_q, r0_q;
  logic [7:0] vx, vy, v0;
  logic [11:0] stk_q;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv && s1_v_r;
  // an empty stage takes a request even while the result waits
  assign s1_ld = adv || !s1_v_r;

  logic [3:0] rd_x, rd_y;
  logic [3:0] rf_ra_x, rf_ra_y;
  assign rd_x = in_instr_word[11:8];
  assign rd_y = in_instr_word[7:4];
  assign rf_ra_x = s1_ld ? rd_x : s1_w_r[11:8];
  assign rf_ra_y = s1_ld ? rd_y : s1_w_r[7:4];

  // three read copies of the register file, same write port
  c8ex_ram #(.WIDTH(8), .DEPTH(16)) u_rf_x (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .raddr(rf_ra_x), .rdata(rx_q));
  c8ex_ram #(.WIDTH(8), .DEPTH(16)) u_rf_y (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .raddr(rf_ra_y), .rdata(ry_q));
  c8ex_ram #(.WIDTH(8), .DEPTH(16)) u_rf_0 (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .raddr(4'd0), .rdata(r0_q));

  // forward what execute wrote in the cycle the read happened
  function automatic logic [7:0] fwd(input logic [3:0] a, input logic [7:0] q,
                                     input logic v, input logic [3:0] fa,
                                     input logic [7:0] fd, input logic fv,
                                     input logic [7:0] ff);
    logic [7:0] r;
    r = q;
    if (v && fa == a) r = fd;
    if (fv && a == 4'hF) r = ff;
    return r;
  endfunction

  // flag reg VF is kept in a flop too, so register reads of VF use vf_r
  assign vx = (s1_w_r[11:8] == 4'hF) ? vf_r :
              fwd(s1_w_r[11:8], rvx_r ? rx_q : 8'd0,
                  fw_v_r, fw_a_r, fw_d_r, fwf_v_r, fwf_d_r);
  assign vy = (s1_w_r[7:4] == 4'hF) ? vf_r :
              fwd(s1_w_r[7:4], rvy_r ? ry_q : 8'd0,
                  fw_v_r, fw_a_r, fw_d_r, fwf_v_r, fwf_d_r);
  assign v0 = fwd(4'd0, rv0_r ? r0_q : 8'd0,
                  fw_v_r, fw_a_r, fw_d_r, fwf_v_r, fwf_d_r);

  // stack ram: read address follows the live depth
  logic            stk_we;
  logic [SAW-1:0]  stk_wa;
  logic [SAW-1:0]  stk_ra;
  logic [11:0]     stk_wd;
  logic            stkf_v_r;
  logic [11:0]     stkf_d_r;
  logic [11:0]     stk_top;

  assign stk_ra = SAW'(sd_nxt - SDW'(1));
  c8ex_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .raddr(stk_ra), .rdata(stk_q));
  assign stk_top = stkf_v_r ? stkf_d_r : stk_q;

  // execute
  logic        ex_go;
  logic [3:0]  hi, x, n;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2, pc4;
  logic        wr, hf, skip;
  logic [7:0]  res, flg;
  logic [8:0]  sum;
  status_t     stat;

  assign ex_go = s1_v_r && adv;
  assign hi  = s1_w_r[15:12];
  assign x   = s1_w_r[11:8];
  assign n   = s1_w_r[3:0];
  assign kk  = s1_w_r[7:0];
  assign nnn = s1_w_r[11:0];
  assign pc2 = pc_r + PcStep;
  assign pc4 = pc_r + PcStep + PcStep;

  always_comb begin
    wr = 1'b0; hf = 1'b0; skip = 1'b0;
    res = '0; flg = '0; sum = '0;
    stat = ST_OK;
    pc_nxt = pc_r; idx_nxt = idx_r; sd_nxt = sd_r;
    dt_nxt = dt_r; st_nxt = st_r;
    stk_we = 1'b0; stk_wa = SAW'(sd_r); stk_wd = pc2;
    if (ex_go) begin
      if (s1_op_r == OP_TICK) begin
        if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
        if (st_r != 8'd0) st_nxt = st_r - 8'd1;
      end else begin
        pc_nxt = pc2;
        case (hi)
          4'h0: begin
            if (s1_w_r == InstrRet) begin
              if (sd_r == '0) stat = ST_UNDER;
              else begin
                sd_nxt = sd_r - SDW'(1);
                pc_nxt = stk_top;
              end
            end else if (s1_w_r == InstrCls) stat = ST_UNSUP;
          end
          4'h1: pc_nxt = nnn;
          4'h2: begin
            if (sd_r >= SdFull) stat = ST_OVER;
            else begin
              stk_we = 1'b1;
              sd_nxt = sd_r + SDW'(1);
              pc_nxt = nnn;
            end
          end
          4'h3: skip = (vx == kk);
          4'h4: skip = (vx != kk);
          4'h5: if (n != 4'd0) stat = ST_UNSUP; else skip = (vx == vy);
          4'h6: begin wr = 1'b1; res = kk; end
          4'h7: begin wr = 1'b1; res = vx + kk; end
          4'h8: begin
            case (n)
              4'h0: begin wr = 1'b1; res = vy; end
              4'h1: begin wr = 1'b1; res = vx | vy; end
              4'h2: begin wr = 1'b1; res = vx & vy; end
              4'h3: begin wr = 1'b1; res = vx ^ vy; end
              4'h4: begin
                sum = {1'b0, vx} + {1'b0, vy};
                wr = 1'b1; res = sum[7:0]; hf = 1'b1; flg = {7'd0, sum[8]};
              end
              4'h5: begin
                wr = 1'b1; res = vx - vy; hf = 1'b1; flg = {7'd0, vx >= vy};
              end
              4'h6: begin
                wr = 1'b1; res = {1'b0, vx[7:1]}; hf = 1'b1; flg = {7'd0, vx[0]};
              end
              4'h7: begin
                wr = 1'b1; res = vy - vx; hf = 1'b1; flg = {7'd0, vy >= vx};
              end
              4'hE: begin
                wr = 1'b1; res = {vx[6:0], 1'b0}; hf = 1'b1; flg = {7'd0, vx[7]};
              end
              default: stat = ST_UNSUP;
            endcase
          end
          4'h9: if (n != 4'd0) stat = ST_UNSUP; else skip = (vx != vy);
          4'hA: idx_nxt = {4'd0, nnn};
          4'hB: pc_nxt = nnn + {4'd0, v0};
          4'hC: begin wr = 1'b1; res = s1_rnd_r & kk; end
          4'hD: stat = ST_UNSUP;
          4'hE: begin
            if (kk == 8'h9E) skip = (vx[7:4] == 4'd0) && s1_key_r[vx[3:0]];
            else if (kk == 8'hA1) skip = !((vx[7:4] == 4'd0) && s1_key_r[vx[3:0]]);
            else stat = ST_UNSUP;
          end
          default: begin
            case (kk)
              8'h07: begin wr = 1'b1; res = dt_r; end
              8'h15: dt_nxt = vx;
              8'h18: st_nxt = vx;
              8'h1E: idx_nxt = idx_r + {8'd0, vx};
              default: stat = ST_UNSUP;
            endcase
          end
        endcase
        if (skip) pc_nxt = pc4;
      end
    end
  end

  // final register writes: flag after result
  always_comb begin
    vf_nxt = vf_r;
    if (ex_go && wr && x == 4'hF) vf_nxt = res;
    if (ex_go && hf) vf_nxt = flg;
  end

  assign rf_we = ex_go && wr;
  assign rf_wa = x;
  assign rf_wd = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= StartAddrRst;
      pc_r <= StartAddrRst;
      idx_r <= '0; sd_r <= '0; dt_r <= '0; st_r <= '0; vf_r <= '0;
      s1_v_r <= 1'b0; out_valid <= 1'b0;
      fw_v_r <= 1'b0; fwf_v_r <= 1'b0; stkf_v_r <= 1'b0;
      rv_r <= '0;
    end else begin
      if (cfg_we) start_r <= cfg_wdata;
      pc_r <= pc_nxt; idx_r <= idx_nxt; sd_r <= sd_nxt;
      dt_r <= dt_nxt; st_r <= st_nxt; vf_r <= vf_nxt;
      if (rf_we) rv_r[rf_wa] <= 1'b1;
      // forwarding tracks writes landing while a read is outstanding
      fw_v_r <= rf_we;
      fwf_v_r <= ex_go && (hf || (wr && x == 4'hF));
      stkf_v_r <= stk_we && (stk_wa == stk_ra);
      if (s1_ld) s1_v_r <= in_valid;
      if (adv) out_valid <= s1_v_r;
    end
  end

  // reset restores the start value, so it never reaches the pc
  logic unused_start;
  assign unused_start = ^start_r;

  always_ff @(posedge clk) begin
    fw_a_r <= rf_wa; fw_d_r <= rf_wd; fwf_d_r <= vf_nxt; stkf_d_r <= stk_wd;
    rvx_r <= rv_r[rf_ra_x]; rvy_r <= rv_r[rf_ra_y]; rv0_r <= rv_r[0];
    if (s1_ld) begin
      s1_op_r <= in_op; s1_w_r <= in_instr_word;
      s1_rnd_r <= in_random_byte; s1_key_r <= in_key_down_mask;
    end
    if (ex_go) begin
      out_next_pc <= pc_nxt;
      out_index_value <= idx_nxt;
      out_reg_written <= wr;
      out_reg_number <= wr ? x : 4'd0;
      out_reg_value <= !wr ? 8'd0 : (x == 4'hF) ? vf_nxt : res;
      out_flag_value <= vf_nxt;
      out_delay_value <= dt_nxt;
      out_sound_on <= st_nxt != 8'd0;
      out_status <= stat;
    end
  end

endmodule

### rtl/core/c8ex_checker.sv
`timescale 1ns / 1ps
`include "chip8_instruction_execute_core_macros.svh"
module c8ex_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_reg_written,
  input logic [3:0]  out_reg_number,
  input logic [7:0]  out_reg_value,
  input logic [1:0]  out_status
);

  import c8ex_pkg::*;

  `C8_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
    "result dropped while stalled")
  `C8_ASSERT_IMP(a_no_write_num, clk, rst_n, out_valid && !out_reg_written,
    out_reg_number == 4'd0 && out_reg_value == 8'd0, "stray register report")
  `C8_ASSERT_IMP(a_write_ok, clk, rst_n, out_valid && out_reg_written,
    out_status == ST_OK, "register write with error status")
  `C8_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall,
    "input stalled with output free")

endmodule

bind chip8_instruction_execute_core c8ex_checker u_c8ex_checker (.*);
